// ===== hdl/i2csrm_pkg.sv =====
`default_nettype none
// ============================================================================
// i2csrm_pkg
// Shared types and constants for the register map behind the I2C slave.
// ============================================================================
package i2csrm_pkg;

  // field widths
  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // bus event codes
  localparam logic [FUNC_W-1:0] FUNC_TX_ADDR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TX_REQ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RX_ADDR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RX_BYTE = 3'd3;

  // register indexes
  localparam logic [BYTE_W-1:0] IDX_ID_LO    = 8'h30;
  localparam logic [BYTE_W-1:0] IDX_ID_HI    = 8'h31;
  localparam logic [BYTE_W-1:0] IDX_EXT_OUT  = 8'hC0;
  localparam logic [BYTE_W-1:0] IDX_BUCK     = 8'hC1;
  localparam logic [BYTE_W-1:0] IDX_PIN      = 8'hD0;
  localparam logic [BYTE_W-1:0] IDX_VIN_HI   = 8'hD1;
  localparam logic [BYTE_W-1:0] IDX_VIN_LO   = 8'hD2;
  localparam logic [BYTE_W-1:0] IDX_BATT_HI  = 8'hD3;
  localparam logic [BYTE_W-1:0] IDX_BATT_LO  = 8'hD4;

  // fixed read values
  localparam logic [BYTE_W-1:0] VAL_ID_LO    = 8'h00;
  localparam logic [BYTE_W-1:0] VAL_ID_HI    = 8'h11;
  localparam logic [BYTE_W-1:0] VAL_PIN_LOW  = 8'h00;
  localparam logic [BYTE_W-1:0] VAL_UNKNOWN  = 8'hAA;
  localparam logic [BYTE_W-1:0] VAL_NOT_TX   = 8'hCC;

  // configuration register
  localparam logic [BYTE_W-1:0] INPUT_HIGH_CODE_RST = 8'd32;
  localparam logic [0:0]        CFG_INPUT_HIGH_CODE = 1'b0;

  // bus phase
  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_EXPECT_REG = 2'd1,
    PH_WRITE      = 2'd2,
    PH_TRANSMIT   = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/i2csrm_if.sv =====
`default_nettype none
// ============================================================================
// i2csrm channel interfaces
// Valid/ready channels for bus events in and result items out.
// ============================================================================
interface i2csrm_evt_if;
  logic                                  valid;
  logic                                  ready;
  logic [i2csrm_pkg::FUNC_W-1:0]         func;
  logic [i2csrm_pkg::BYTE_W-1:0]         rx_byte;
  logic                                  ext_input_level;
  logic [i2csrm_pkg::SAMPLE_W-1:0]       vin_sample;
  logic [i2csrm_pkg::SAMPLE_W-1:0]       batt_sample;

  modport source (
    output valid, func, rx_byte, ext_input_level, vin_sample, batt_sample,
    input  ready
  );
  modport sink (
    input  valid, func, rx_byte, ext_input_level, vin_sample, batt_sample,
    output ready
  );
endinterface

interface i2csrm_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  tx_valid;
  logic [i2csrm_pkg::BYTE_W-1:0]         tx_byte;
  logic                                  ext_output_level;
  logic                                  buck_enable;
  logic                                  ack_rearm;

  modport source (
    output valid, tx_valid, tx_byte, ext_output_level, buck_enable, ack_rearm,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_byte, ext_output_level, buck_enable, ack_rearm,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/i2c_slave_register_map.sv =====
`default_nettype none
// flow: an accepted event lands in the input register at the accepting edge; its result is
//   registered when the output register is free or transfers, so a res stall holds it there
// throughput: one event per cycle unless res stalls; the output register frees as it transfers
// reset: rst (synchronous) empties both stages, sets phase idle, clears index and
//   pin levels, and loads input_high_code with 32
// ============================================================================
// i2c_slave_register_map
// Register map behind an I2C slave: decodes bus events, tracks the transfer
// phase and selected register, drives two control pins and answers reads.
// ============================================================================
module i2c_slave_register_map (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [i2csrm_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [i2csrm_pkg::PDATA_W-1:0]     pwdata,
  output logic      [i2csrm_pkg::PDATA_W-1:0]     prdata,
  output logic                                    pready,
  // channels
  i2csrm_evt_if.sink                              evt,
  i2csrm_res_if.source                            res
);

  // configuration register
  logic [i2csrm_pkg::BYTE_W-1:0] input_high_code;
  logic                          cfg_write;
  logic                          cfg_hit;

  // input register
  logic                            s1_valid;
  logic [i2csrm_pkg::FUNC_W-1:0]   s1_func;
  logic [i2csrm_pkg::BYTE_W-1:0]   s1_rx_byte;
  logic                            s1_pin;
  logic [i2csrm_pkg::SAMPLE_W-1:0] s1_vin;
  logic [i2csrm_pkg::SAMPLE_W-1:0] s1_batt;
  logic                            s1_fire;

  // block state
  i2csrm_pkg::phase_t              phase, phase_next;
  logic [i2csrm_pkg::BYTE_W-1:0]   reg_index, reg_index_next;
  logic                            ext_output, ext_output_next;
  logic                            buck_on, buck_on_next;

  // result register
  logic                            out_valid;
  logic                            out_tx_valid, out_tx_valid_next;
  logic [i2csrm_pkg::BYTE_W-1:0]   out_tx_byte, out_tx_byte_next;
  logic                            out_ext;
  logic                            out_buck;
  logic                            out_rearm, out_rearm_next;
  logic [i2csrm_pkg::BYTE_W-1:0]   read_byte;

  // apb decode
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == i2csrm_pkg::CFG_INPUT_HIGH_CODE);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata[i2csrm_pkg::BYTE_W-1:0] = input_high_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_high_code <= i2csrm_pkg::INPUT_HIGH_CODE_RST;
    end else if (cfg_write && cfg_hit) begin
      input_high_code <= pwdata[i2csrm_pkg::BYTE_W-1:0];
    end
  end

  // pipeline handshake
  assign s1_fire   = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_func    <= evt.func;
      s1_rx_byte <= evt.rx_byte;
      s1_pin     <= evt.ext_input_level;
      s1_vin     <= evt.vin_sample;
      s1_batt    <= evt.batt_sample;
    end
  end

  // next state from the event
  always_comb begin
    phase_next      = phase;
    reg_index_next  = reg_index;
    ext_output_next = ext_output;
    buck_on_next    = buck_on;
    unique case (s1_func)
      i2csrm_pkg::FUNC_TX_ADDR: begin
        phase_next = i2csrm_pkg::PH_TRANSMIT;
      end
      i2csrm_pkg::FUNC_RX_ADDR: begin
        phase_next     = i2csrm_pkg::PH_EXPECT_REG;
        reg_index_next = '0;
      end
      i2csrm_pkg::FUNC_RX_BYTE: begin
        // first byte selects, later bytes write
        if (phase == i2csrm_pkg::PH_EXPECT_REG) begin
          phase_next     = i2csrm_pkg::PH_WRITE;
          reg_index_next = s1_rx_byte;
        end else if (phase == i2csrm_pkg::PH_WRITE) begin
          if (reg_index == i2csrm_pkg::IDX_EXT_OUT) begin
            ext_output_next = (s1_rx_byte != '0);
          end else if (reg_index == i2csrm_pkg::IDX_BUCK) begin
            buck_on_next = (s1_rx_byte != '0);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2csrm_pkg::PH_IDLE;
      reg_index  <= '0;
      ext_output <= 1'b0;
      buck_on    <= 1'b0;
    end else if (s1_fire) begin
      phase      <= phase_next;
      reg_index  <= reg_index_next;
      ext_output <= ext_output_next;
      buck_on    <= buck_on_next;
    end
  end

  // read mux by selected register
  always_comb begin
    unique case (reg_index)
      i2csrm_pkg::IDX_ID_LO:   read_byte = i2csrm_pkg::VAL_ID_LO;
      i2csrm_pkg::IDX_ID_HI:   read_byte = i2csrm_pkg::VAL_ID_HI;
      i2csrm_pkg::IDX_PIN:     read_byte = s1_pin ? input_high_code : i2csrm_pkg::VAL_PIN_LOW;
      i2csrm_pkg::IDX_VIN_HI:  read_byte = s1_vin[i2csrm_pkg::SAMPLE_W-1:i2csrm_pkg::BYTE_W];
      i2csrm_pkg::IDX_VIN_LO:  read_byte = s1_vin[i2csrm_pkg::BYTE_W-1:0];
      i2csrm_pkg::IDX_BATT_HI: read_byte = s1_batt[i2csrm_pkg::SAMPLE_W-1:i2csrm_pkg::BYTE_W];
      i2csrm_pkg::IDX_BATT_LO: read_byte = s1_batt[i2csrm_pkg::BYTE_W-1:0];
      default:                 read_byte = i2csrm_pkg::VAL_UNKNOWN;
    endcase
  end

  // result fields
  always_comb begin
    out_tx_valid_next = 1'b0;
    out_tx_byte_next  = '0;
    out_rearm_next    = 1'b0;
    unique case (s1_func)
      i2csrm_pkg::FUNC_TX_ADDR, i2csrm_pkg::FUNC_RX_ADDR, i2csrm_pkg::FUNC_RX_BYTE: begin
      end
      i2csrm_pkg::FUNC_TX_REQ: begin
        out_tx_valid_next = 1'b1;
        out_tx_byte_next  = (phase == i2csrm_pkg::PH_TRANSMIT) ? read_byte
                                                                : i2csrm_pkg::VAL_NOT_TX;
      end
      default: begin
        out_rearm_next = 1'b1;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_tx_valid <= out_tx_valid_next;
      out_tx_byte  <= out_tx_byte_next;
      out_ext      <= ext_output_next;
      out_buck     <= buck_on_next;
      out_rearm    <= out_rearm_next;
    end
  end

  assign res.valid            = out_valid;
  assign res.tx_valid         = out_tx_valid;
  assign res.tx_byte          = out_tx_byte;
  assign res.ext_output_level = out_ext;
  assign res.buck_enable      = out_buck;
  assign res.ack_rearm        = out_rearm;

`ifndef ASSERT_OFF
  // a byte request never also rearms acknowledge
  a_req_not_rearm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_tx_valid && out_rearm))
    else $error("tx_valid and ack_rearm both set");

  // no byte is sent without a request
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_tx_valid) |-> (out_tx_byte == '0))
    else $error("tx_byte nonzero without tx_valid");

  // receiver address match starts a fresh register selection
  a_rx_addr: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_func == i2csrm_pkg::FUNC_RX_ADDR) |=>
      (phase == i2csrm_pkg::PH_EXPECT_REG && reg_index == '0))
    else $error("rx address match did not reset selection");

  // external output only moves on a write to its register
  a_ext_write: assert property (@(posedge clk) disable iff (rst)
    (ext_output != $past(ext_output)) |->
      $past(s1_fire && s1_func == i2csrm_pkg::FUNC_RX_BYTE &&
            phase == i2csrm_pkg::PH_WRITE && reg_index == i2csrm_pkg::IDX_EXT_OUT))
    else $error("external output changed without a write");

  // an empty input register always takes an event
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> evt.ready)
    else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Checks the I2C slave register map one bus event at a time. A directed table
// covers the fixed replies and the discard/no-effect cases, then random write
// and read transactions mixed with stray events run under several pin-code
// settings. Every reply is scored against an in-bench model of the map, with
// random idles on both channels, a long output stall and full drains.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2csrm_pkg::*;

  // events beyond the package codes
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned       CYCLE_LIMIT = 500_000;
  localparam int                PHASE_ITEMS = 350;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [BYTE_W-1:0]   rx_byte;
    logic                pin;
    logic [SAMPLE_W-1:0] vin;
    logic [SAMPLE_W-1:0] batt;
  } bus_event_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              ext_out;
    logic              buck;
    logic              rearm;
  } reply_t;

  typedef struct {
    bus_event_t ev;
    bit         typed;
    reply_t     want;
  } step_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  i2csrm_evt_if evt_ch ();
  i2csrm_res_if res_ch ();

  i2c_slave_register_map u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .evt     (evt_ch),
    .res     (res_ch)
  );

  // model state of the register map
  phase_t            map_phase;
  logic [BYTE_W-1:0] map_index;
  logic              map_ext_out;
  logic              map_buck;
  logic [BYTE_W-1:0] map_pin_code;

  reply_t      reply_q[$];
  step_row_t   directed_rows[$];
  reply_t      mon_want;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned replies_checked;
  int unsigned tx_reads;
  bit          src_steady;
  bit          sink_steady;
  int          stall_hold;
  logic [BYTE_W-1:0] code_c;
  logic [BYTE_W-1:0] code_d;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // advance the model by one bus event and return its reply
  function automatic reply_t apply_bus_event(bus_event_t ev);
    reply_t r;
    r = '0;
    case (ev.func)
      FUNC_TX_ADDR: map_phase = PH_TRANSMIT;
      FUNC_TX_REQ: begin
        r.tx_valid = 1'b1;
        if (map_phase != PH_TRANSMIT) begin
          r.tx_byte = VAL_NOT_TX;
        end else begin
          case (map_index)
            IDX_ID_LO:   r.tx_byte = VAL_ID_LO;
            IDX_ID_HI:   r.tx_byte = VAL_ID_HI;
            IDX_PIN:     r.tx_byte = ev.pin ? map_pin_code : VAL_PIN_LOW;
            IDX_VIN_HI:  r.tx_byte = ev.vin[15:8];
            IDX_VIN_LO:  r.tx_byte = ev.vin[7:0];
            IDX_BATT_HI: r.tx_byte = ev.batt[15:8];
            IDX_BATT_LO: r.tx_byte = ev.batt[7:0];
            default:     r.tx_byte = VAL_UNKNOWN;
          endcase
        end
      end
      FUNC_RX_ADDR: begin
        map_phase = PH_EXPECT_REG;
        map_index = '0;
      end
      FUNC_RX_BYTE: begin
        // first byte selects, later bytes write; idle/transmit drops the byte
        if (map_phase == PH_EXPECT_REG) begin
          map_phase = PH_WRITE;
          map_index = ev.rx_byte;
        end else if (map_phase == PH_WRITE) begin
          if (map_index == IDX_EXT_OUT) map_ext_out = (ev.rx_byte != '0);
          else if (map_index == IDX_BUCK) map_buck = (ev.rx_byte != '0);
        end
      end
      default: r.rearm = 1'b1;
    endcase
    r.ext_out = map_ext_out;
    r.buck    = map_buck;
    return r;
  endfunction

  // offer one event; predict its reply at the accepting edge
  task automatic offer_event(input bus_event_t ev, input bit typed, input reply_t want);
    int gap;
    reply_t guess;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      evt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    evt_ch.valid           <= 1'b1;
    evt_ch.func            <= ev.func;
    evt_ch.rx_byte         <= ev.rx_byte;
    evt_ch.ext_input_level <= ev.pin;
    evt_ch.vin_sample      <= ev.vin;
    evt_ch.batt_sample     <= ev.batt;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    guess = apply_bus_event(ev);
    reply_q.push_back(typed ? want : guess);
    events_sent++;
  endtask

  // random pin and converter levels around a given event
  task automatic send(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] rx);
    bus_event_t ev;
    ev.func    = f;
    ev.rx_byte = rx;
    ev.pin     = 1'($urandom_range(0, 1));
    ev.vin     = SAMPLE_W'($urandom_range(0, 65535));
    ev.batt    = SAMPLE_W'($urandom_range(0, 65535));
    offer_event(ev, 1'b0, '0);
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] rx,
                         input logic pin, input logic [SAMPLE_W-1:0] vin,
                         input logic [SAMPLE_W-1:0] batt, input bit typed, input reply_t want);
    step_row_t row;
    row.ev    = '{f, rx, pin, vin, batt};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // stop offering and wait out every outstanding reply
  task automatic drain_replies();
    @(negedge clk);
    evt_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // configuration write followed by a read-back
  task automatic set_pin_code(input logic [BYTE_W-1:0] code);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_INPUT_HIGH_CODE, 2'b00};
    pwdata  <= PDATA_W'(code);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    map_pin_code = code;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_pin_code(code);
  endtask

  task automatic check_pin_code(input logic [BYTE_W-1:0] code);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {CFG_INPUT_HIGH_CODE, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(code)) begin
      mismatches++;
      $display("%0t ns: pin code read expected 0x%0h, got 0x%0h", $time, code, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_index();
    logic [BYTE_W-1:0] picks[12];
    picks = '{IDX_ID_LO, IDX_ID_HI, IDX_EXT_OUT, IDX_BUCK, 8'hC2, IDX_PIN,
              IDX_VIN_HI, IDX_VIN_LO, IDX_BATT_HI, IDX_BATT_LO, 8'h00, 8'hFF};
    if ($urandom_range(0, 9) < 7) return picks[$urandom_range(0, 11)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // random transactions: mostly well-formed writes and reads, some stray events
  task automatic run_traffic(input int count, input int steady_lead);
    int stop_at;
    int sel;
    int k;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      if (steady_lead > 0 && events_sent >= stop_at - count + steady_lead) src_steady = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        send(FUNC_RX_ADDR, BYTE_W'($urandom_range(0, 255)));
        send(FUNC_RX_BYTE, pick_index());
        k = $urandom_range(0, 3);
        repeat (k) send(FUNC_RX_BYTE, $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 4) != 0) send(FUNC_STOP, BYTE_W'($urandom_range(0, 255)));
      end else if (sel < 82) begin
        if ($urandom_range(0, 9) < 6) begin
          send(FUNC_RX_ADDR, BYTE_W'($urandom_range(0, 255)));
          send(FUNC_RX_BYTE, pick_index());
        end
        send(FUNC_TX_ADDR, BYTE_W'($urandom_range(0, 255)));
        k = $urandom_range(1, 4);
        repeat (k) send(FUNC_TX_REQ, BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0) send(FUNC_STOP, BYTE_W'($urandom_range(0, 255)));
      end else begin
        send(FUNC_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // output ready: random stalls, or a long hold requested by the stimulus
  initial begin
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        n = stall_hold;
        stall_hold = 0;
      end else begin
        n = sink_steady ? 0 : idle_len();
      end
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  task automatic flag_field(input string what, input logic [BYTE_W-1:0] want,
                            input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // reply scoring against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: reply with nothing outstanding, expected none, got tx_byte 0x%0h",
                 $time, res_ch.tx_byte);
      end else begin
        mon_want = reply_q.pop_front();
        flag_field("tx_valid", BYTE_W'(mon_want.tx_valid), BYTE_W'(res_ch.tx_valid));
        flag_field("tx_byte", mon_want.tx_byte, res_ch.tx_byte);
        flag_field("ext_output_level", BYTE_W'(mon_want.ext_out),
                   BYTE_W'(res_ch.ext_output_level));
        flag_field("buck_enable", BYTE_W'(mon_want.buck), BYTE_W'(res_ch.buck_enable));
        flag_field("ack_rearm", BYTE_W'(mon_want.rearm), BYTE_W'(res_ch.ack_rearm));
        replies_checked++;
        if (mon_want.tx_valid) tx_reads++;
      end
    end
  end

  // main sequence
  initial begin
    cycles          = 0;
    mismatches      = 0;
    events_sent     = 0;
    replies_checked = 0;
    tx_reads        = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    stall_hold      = 0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    evt_ch.valid           = 1'b0;
    evt_ch.func            = FUNC_STOP;
    evt_ch.rx_byte         = '0;
    evt_ch.ext_input_level = 1'b0;
    evt_ch.vin_sample      = '0;
    evt_ch.batt_sample     = '0;
    map_phase    = PH_IDLE;
    map_index    = '0;
    map_ext_out  = 1'b0;
    map_buck     = 1'b0;
    map_pin_code = INPUT_HIGH_CODE_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the pin code
    check_pin_code(INPUT_HIGH_CODE_RST);

    // directed table: fixed replies, dropped bytes, writes, unknown, sample and pin reads
    add_row(FUNC_TX_REQ, 8'h00, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, {1'b1, VAL_NOT_TX, 3'b000});
    add_row(FUNC_STOP, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b1, {1'b0, 8'h00, 3'b001});
    add_row(FUNC_UNUSED, 8'h00, 1'b1, 16'h0000, 16'hFFFF, 1'b1, {1'b0, 8'h00, 3'b001});
    add_row(FUNC_RX_BYTE, 8'hFF, 1'b0, 16'hFFFF, 16'h0000, 1'b1, {1'b0, 8'h00, 3'b000});
    add_row(FUNC_TX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1, {1'b0, 8'h00, 3'b000});
    add_row(FUNC_TX_REQ, 8'h00, 1'b0, 16'h1234, 16'h5678, 1'b1, {1'b1, VAL_UNKNOWN, 3'b000});
    add_row(FUNC_RX_BYTE, IDX_EXT_OUT, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, IDX_EXT_OUT, 1'b1, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'h01, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'h80, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, IDX_BUCK, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'hC2, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, IDX_VIN_HI, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_TX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_TX_REQ, 8'h00, 1'b0, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_row(FUNC_TX_REQ, 8'h00, 1'b1, 16'h00FF, 16'hFFFF, 1'b0, '0);
    add_row(FUNC_RX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_RX_BYTE, IDX_PIN, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_TX_ADDR, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(FUNC_TX_REQ, 8'h00, 1'b1, 16'h0000, 16'h0000, 1'b0, '0);
    foreach (directed_rows[i])
      offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    drain_replies();

    // pin code zero, no idling on either side
    set_pin_code(8'h00);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    run_traffic(PHASE_ITEMS, 0);
    drain_replies();

    // pin code all ones; long output hold while input keeps coming
    set_pin_code(8'hFF);
    sink_steady = 1'b0;
    stall_hold  = 60;
    run_traffic(PHASE_ITEMS, 40);
    drain_replies();

    // random pin codes with random idles
    src_steady = 1'b0;
    code_c = BYTE_W'($urandom_range(1, 254));
    set_pin_code(code_c);
    run_traffic(PHASE_ITEMS, 0);
    drain_replies();
    code_d = BYTE_W'($urandom_range(1, 254));
    set_pin_code(code_d);
    run_traffic(PHASE_ITEMS, 0);
    drain_replies();
    repeat (10) @(posedge clk);

    $display("run covered %0d bus events, %0d replies scored, %0d of them byte reads",
             events_sent, replies_checked, tx_reads);
    $display("pin codes used: 0x%0h 0x00 0xff 0x%0h 0x%0h, with a 60-cycle output hold",
             INPUT_HIGH_CODE_RST, code_c, code_d);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
